[hdl/srts_pkg.sv]
package srts_pkg;

	typedef logic [19:0] id_t;
	typedef logic [30:0] pay_t;
	typedef logic [5:0]  slot_t;
	typedef logic [6:0]  cnt_t;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_code_t;

	typedef enum logic [2:0] {
		STAT_ADDED   = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_FOUND   = 3'd2,
		STAT_MISSING = 3'd3,
		STAT_CLEARED = 3'd4
	} status_t;

	typedef struct packed {
		req_code_t req_type;
		id_t       key_id;
		pay_t      pay_value;
	} req_t;

	typedef struct packed {
		status_t status;
		id_t     found_id;
		pay_t    found_pay;
		slot_t   slot_index;
		cnt_t    entry_count;
	} rsp_t;

	typedef struct packed {
		id_t   id;
		pay_t  pay;
		slot_t slot;
	} rec_t;

endpackage

[hdl/srts_ifs.sv]
interface srts_req_if;
	logic valid;
	logic ready;
	srts_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface srts_rsp_if;
	logic valid;
	logic ready;
	srts_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hdl/srts_rec_ram.sv]
module srts_rec_ram #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  srts_pkg::rec_t           wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output srts_pkg::rec_t           rd_data
);

	srts_pkg::rec_t mem_q [DEPTH];
	srts_pkg::rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/sorted_record_table_search_core.sv]
// channel | role | payload
// --------+------+---------------------------------------------------------
// req     | sink | req_type, key_id, pay_value
// rsp     | src  | status, found_id, found_pay, slot_index, entry_count
//
// One transaction at a time. A probe is a registered RAM read, then a compare; probes
// are at most ceil(log2(count+1)). Clear, full and unused code go straight to the
// response. Lookup ends with a read and compare of the record at the search position,
// or reports missing at once when the search runs past the last record. Add searches,
// shifts count - insertion position entries up, one entry per cycle through the single
// write port, then inserts. Reset empties the table at once, no clearing pass. A new
// request is taken while a result still waits on rsp; only the next result waits for rsp.ready.
module sorted_record_table_search_core #(
	parameter int TABLE_DEPTH = 64
) (
	input logic         clk,
	input logic         arst_n,
	srts_req_if.sink    req,
	srts_rsp_if.source  rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CMP,
		ST_SHIFT,
		ST_INSERT,
		ST_LKCMP,
		ST_RESP
	} state_t;

	state_t          state_q;
	srts_pkg::req_t  req_q;
	srts_pkg::rsp_t  res_q;
	srts_pkg::rsp_t  out_q;
	logic            out_valid_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   mid_q;
	logic [CW-1:0]   sh_q;

	logic [CW:0]     mid_sum;
	logic [CW-1:0]   mid;
	logic [CW-1:0]   count_inc;
	logic [CW-1:0]   count_dec;
	logic [CW-1:0]   sh_inc;
	logic [CW-1:0]   sh_dec;
	logic            go_right;
	logic            is_add;
	logic            out_load;
	srts_pkg::rsp_t  res_init;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	srts_pkg::rec_t  wr_data;
	logic [AW-1:0]   rd_addr;
	srts_pkg::rec_t  rd_data;

	srts_rec_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CW:1];
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign sh_inc    = sh_q + 1'b1;
	assign sh_dec    = sh_q - 1'b1;
	assign is_add    = (req_q.req_type == srts_pkg::REQ_ADD);
	// add searches past equal ids (upper bound), lookup stops at the first one
	assign go_right  = is_add ? (rd_data.id <= req_q.key_id) : (rd_data.id < req_q.key_id);
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		res_init             = '0;
		res_init.entry_count = srts_pkg::cnt_t'(count_q);
		case (req.data.req_type)
			srts_pkg::REQ_ADD: begin
				if (count_q >= DEPTH_C) begin
					res_init.status = srts_pkg::STAT_FULL;
				end
			end
			srts_pkg::REQ_LOOKUP: begin
			end
			srts_pkg::REQ_CLEAR: begin
				res_init.status      = srts_pkg::STAT_CLEARED;
				res_init.entry_count = '0;
			end
			default: begin
				res_init.status = srts_pkg::STAT_MISSING;
			end
		endcase
	end

	always_comb begin
		rd_addr = mid[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = sh_inc[AW-1:0];
		wr_data = rd_data;
		case (state_q)
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					rd_addr = mid[AW-1:0];
				end else if (is_add) begin
					rd_addr = count_dec[AW-1:0];
				end else begin
					rd_addr = lo_q[AW-1:0];
				end
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				rd_addr = sh_dec[AW-1:0];
			end
			ST_INSERT: begin
				wr_en        = 1'b1;
				wr_addr      = lo_q[AW-1:0];
				wr_data.id   = req_q.key_id;
				wr_data.pay  = req_q.pay_value;
				wr_data.slot = srts_pkg::slot_t'(count_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			sh_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						lo_q  <= '0;
						hi_q  <= count_q;
						res_q <= res_init;
						case (req.data.req_type)
							srts_pkg::REQ_ADD: begin
								if (count_q >= DEPTH_C) begin
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_SEARCH;
								end
							end
							srts_pkg::REQ_LOOKUP: begin
								state_q <= ST_SEARCH;
							end
							srts_pkg::REQ_CLEAR: begin
								count_q <= '0;
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else if (is_add) begin
						if (count_q > lo_q) begin
							sh_q    <= count_dec;
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_INSERT;
						end
					end else if (lo_q < count_q) begin
						state_q <= ST_LKCMP;
					end else begin
						res_q.status <= srts_pkg::STAT_MISSING;
						state_q      <= ST_RESP;
					end
				end
				ST_CMP: begin
					if (go_right) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= ST_SEARCH;
				end
				ST_SHIFT: begin
					if (sh_q > lo_q) begin
						sh_q <= sh_dec;
					end else begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					count_q           <= count_inc;
					res_q.status      <= srts_pkg::STAT_ADDED;
					res_q.found_id    <= req_q.key_id;
					res_q.found_pay   <= req_q.pay_value;
					res_q.slot_index  <= srts_pkg::slot_t'(count_q);
					res_q.entry_count <= srts_pkg::cnt_t'(count_inc);
					state_q           <= ST_RESP;
				end
				ST_LKCMP: begin
					if (rd_data.id == req_q.key_id) begin
						res_q.status     <= srts_pkg::STAT_FOUND;
						res_q.found_id   <= rd_data.id;
						res_q.found_pay  <= rd_data.pay;
						res_q.slot_index <= rd_data.slot;
					end else begin
						res_q.status <= srts_pkg::STAT_MISSING;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("record count beyond table depth");

	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> mid_q < count_q)
		else $error("search probe outside held records");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) <= count_q) && (count_q < DEPTH_C))
		else $error("record write outside table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while previous one in flight");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result issued outside response state");

endmodule
